@@ rtl/kvfe_pkg.sv @@
`timescale 1ns / 1ps

package kvfe_pkg;

	// Line and key limits.
	localparam int KEY_MAX  = 8;
	localparam int MAX_LINE = 256;
	localparam int POS_W    = $clog2(MAX_LINE + 1);
	localparam int OFF_W    = $clog2(MAX_LINE);
	localparam int KIDX_W   = $clog2(KEY_MAX);
	localparam int KEY_W    = 8 * KEY_MAX;
	localparam int HIST_W   = 8 * (KEY_MAX - 1);
	localparam int KLEN_W   = 4;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W    = 64;

	localparam logic [7:0] CHAR_EQUALS = 8'h3D;
	localparam logic [7:0] CHAR_SPACE  = 8'h20;
	localparam logic [7:0] CHAR_TAB    = 8'h09;
	localparam logic [7:0] CHAR_CR     = 8'h0D;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 1'b1;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NO_KEY    = 3'd1,
		ST_NO_EQUALS = 3'd2,
		ST_EMPTY     = 3'd3,
		ST_TOO_LONG  = 3'd4
	} status_t;

	// Line parsing phase.
	typedef enum logic [2:0] {
		PH_KEY   = 3'b001,
		PH_EQ    = 3'b010,
		PH_VALUE = 3'b100
	} phase_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} in_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] value_start;
		logic [8:0] value_length;
	} out_item_t;

endpackage

@@ rtl/key_value_field_extractor.sv @@
`timescale 1ns / 1ps

// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_ready   in_item (char_code, last_char)
// out      output     out_valid / out_ready out_item (status, value_start, value_length)
// cfg      input      cfg_we                cfg_index, cfg_data
//
// One character is taken per cycle unless the input stalls, as described below.
// The character register feeds the key window compare and phase update, which load the
// result register. Reset clears the line state, the key bytes and both valid flags.
// A waiting result stalls the input only when a further last character has to be retired.

module key_value_field_extractor (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  kvfe_pkg::in_item_t            in_item,
	output logic                          out_valid,
	input  logic                          out_ready,
	output kvfe_pkg::out_item_t           out_item,
	input  logic                          cfg_we,
	input  logic [kvfe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [kvfe_pkg::CFG_W-1:0]    cfg_data
);
	import kvfe_pkg::*;

	// Configuration registers.
	logic [KEY_W-1:0]  key_bytes_q;
	logic [KLEN_W-1:0] key_length_q;

	// Input register.
	logic     valid_s1;
	in_item_t item_s1;

	// Line state.
	logic [HIST_W-1:0] recent_q;
	logic [POS_W-1:0]  position_q;
	phase_t            phase_q;
	logic [OFF_W-1:0]  start_q;
	logic [OFF_W-1:0]  last_text_q;
	logic              seen_text_q;
	logic              over_q;

	// Output register.
	logic      out_valid_q;
	out_item_t out_item_q;

	logic advance_s1;
	logic fire_s1;

	// Next line state for the character in the input register.
	logic [POS_W-1:0]  n_position;
	logic [HIST_W-1:0] n_recent;
	phase_t            n_phase;
	logic [OFF_W-1:0]  n_start;
	logic [OFF_W-1:0]  n_last_text;
	logic              n_seen_text;
	logic              n_over;
	logic [KEY_W-1:0]  window;
	logic [KLEN_W-1:0] key_len_eff;
	logic              key_hit;
	logic              is_blank;
	logic [OFF_W:0]    span;
	out_item_t         result;

	// A character retires unless it ends a line and the result register is full and not being read.
	assign advance_s1 = !item_s1.last_char || !out_valid_q || out_ready;
	assign fire_s1    = valid_s1 && advance_s1;
	assign in_ready   = !valid_s1 || advance_s1;
	assign out_valid  = out_valid_q;
	assign out_item   = out_item_q;

	// Clamp the configured key length into 1 .. KEY_MAX.
	always_comb begin
		if (key_length_q == '0) begin
			key_len_eff = KLEN_W'(1);
		end else if (key_length_q > KLEN_W'(KEY_MAX)) begin
			key_len_eff = KLEN_W'(KEY_MAX);
		end else begin
			key_len_eff = key_length_q;
		end
	end

	assign window = {recent_q, item_s1.char_code};

	// Compare the key against the most recent characters, newest character last in the key.
	always_comb begin
		logic [KIDX_W-1:0] widx;
		widx = '0;
		key_hit = (position_q >= POS_W'(key_len_eff - KLEN_W'(1)));
		for (int j = 0; j < KEY_MAX; j++) begin
			widx = KIDX_W'(key_len_eff - KLEN_W'(1) - KLEN_W'(j));
			if (KLEN_W'(j) < key_len_eff) begin
				if (key_bytes_q[8*j +: 8] != window[8*widx +: 8]) begin
					key_hit = 1'b0;
				end
			end
		end
	end

	assign is_blank = ((item_s1.char_code >= CHAR_TAB) && (item_s1.char_code <= CHAR_CR))
		|| (item_s1.char_code == CHAR_SPACE);

	// Phase and value tracking for one character.
	always_comb begin
		n_position  = position_q;
		n_recent    = recent_q;
		n_phase     = phase_q;
		n_start     = start_q;
		n_last_text = last_text_q;
		n_seen_text = seen_text_q;
		n_over      = over_q;
		if (position_q >= POS_W'(MAX_LINE)) begin
			n_over = 1'b1;
		end else begin
			unique case (phase_q)
				PH_KEY: begin
					if (key_hit) begin
						n_phase = PH_EQ;
					end
				end
				PH_EQ: begin
					if (item_s1.char_code == CHAR_EQUALS) begin
						n_phase = PH_VALUE;
					end
				end
				PH_VALUE: begin
					if (!is_blank) begin
						if (!seen_text_q) begin
							n_start     = OFF_W'(position_q);
							n_seen_text = 1'b1;
						end
						n_last_text = OFF_W'(position_q);
					end
				end
				default: begin
					n_phase = phase_q;
				end
			endcase
			n_recent   = window[HIST_W-1:0];
			n_position = position_q + POS_W'(1);
		end
	end

	// Result for a line that ends with this character.
	always_comb begin
		span   = {1'b0, n_last_text} - {1'b0, n_start} + (OFF_W+1)'(1);
		result = '0;
		priority if (n_over) begin
			result.status = ST_TOO_LONG;
		end else if (n_phase == PH_KEY) begin
			result.status = ST_NO_KEY;
		end else if (n_phase == PH_EQ) begin
			result.status = ST_NO_EQUALS;
		end else if (!n_seen_text) begin
			result.status = ST_EMPTY;
		end else begin
			result.status       = ST_OK;
			result.value_start  = 8'(n_start);
			result.value_length = 9'(span);
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_bytes_q  <= '0;
			key_length_q <= KLEN_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KEY_BYTES:  key_bytes_q  <= cfg_data[KEY_W-1:0];
				REG_KEY_LENGTH: key_length_q <= cfg_data[KLEN_W-1:0];
				default:        key_bytes_q  <= key_bytes_q;
			endcase
		end
	end

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	// Line state update; a last character returns it to the start of a line.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q    <= '0;
			position_q  <= '0;
			phase_q     <= PH_KEY;
			start_q     <= '0;
			last_text_q <= '0;
			seen_text_q <= 1'b0;
			over_q      <= 1'b0;
		end else if (fire_s1) begin
			if (item_s1.last_char) begin
				recent_q    <= '0;
				position_q  <= '0;
				phase_q     <= PH_KEY;
				start_q     <= '0;
				last_text_q <= '0;
				seen_text_q <= 1'b0;
				over_q      <= 1'b0;
			end else begin
				recent_q    <= n_recent;
				position_q  <= n_position;
				phase_q     <= n_phase;
				start_q     <= n_start;
				last_text_q <= n_last_text;
				seen_text_q <= n_seen_text;
				over_q      <= n_over;
			end
		end
	end

	// Output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && item_s1.last_char) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (fire_s1 && item_s1.last_char) begin
			out_item_q <= result;
		end
	end

`ifndef SYNTHESIS
	// The character count never runs past the line limit.
	a_position_bound: assert property (@(posedge clk) disable iff (!arst_n)
		position_q <= POS_W'(MAX_LINE))
		else $error("position count exceeds line limit");

	// Value text is only recorded once the equals sign has been found.
	a_seen_in_value: assert property (@(posedge clk) disable iff (!arst_n)
		seen_text_q |-> (phase_q == PH_VALUE))
		else $error("value text recorded outside value phase");

	// An error result carries no offset and no length.
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_item_q.status != ST_OK) |->
		(out_item_q.value_start == 8'd0) && (out_item_q.value_length == 9'd0))
		else $error("error result has nonzero fields");

	// A good result always has at least one character.
	a_ok_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_item_q.status == ST_OK) |-> (out_item_q.value_length != 9'd0))
		else $error("good result with empty value");

	// Retiring a last character starts a fresh line and loads a result.
	a_line_restart: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && item_s1.last_char |=> (position_q == '0) && out_valid_q)
		else $error("line state not cleared at line end");
`endif

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;
	import kvfe_pkg::*;

	localparam int LONG_HOLD = 300;
	localparam int SETTLE_CYCLES = 6;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_item;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_KEY_BYTES;
	logic [CFG_W-1:0] cfg_data = '0;

	key_value_field_extractor dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Characters waiting to be sent and field reports still owed by the block.
	in_item_t char_feed[$];
	out_item_t expected_fields[$];
	out_item_t want;
	logic [7:0] scratch[$];
	int unsigned chars_queued = 0;
	int unsigned error_count = 0;

	// Idling controls shared between the stimulus process and the two channel processes.
	logic sender_idle_on = 1'b1;
	logic receiver_idle_on = 1'b1;
	int unsigned hold_requests = 0;
	int unsigned hold_served = 0;
	int unsigned send_gap = 0;
	int unsigned stall_left = 0;

	// Shadow copy of the key registers.
	logic [KEY_W-1:0] key_reg = '0;
	logic [KLEN_W-1:0] key_len_reg = 4'd1;

	// Shadow copy of the line parser state.
	logic [HIST_W-1:0] kv_recent = '0;
	logic [POS_W-1:0] kv_pos = '0;
	phase_t kv_phase = PH_KEY;
	logic [7:0] kv_start = '0;
	logic [7:0] kv_last_text = '0;
	logic kv_seen_text = 1'b0;
	logic kv_overflow = 1'b0;

	initial forever #2 clk = ~clk;

	// The run is cut off here if the block hangs.
	initial begin
		#4000000;
		$display("key_value_field_extractor verification failed");
		$finish;
	end

	function automatic logic is_blank(input logic [7:0] c);
		return (c >= 8'd9 && c <= 8'd13) || c == CHAR_SPACE;
	endfunction

	// A key length of zero acts as one, and anything above the maximum acts as the maximum.
	function automatic int unsigned key_span();
		if (key_len_reg == 0)
			return 1;
		if (key_len_reg > KEY_MAX)
			return KEY_MAX;
		return key_len_reg;
	endfunction

	// The key matches when its last character is the newest one in the window.
	function automatic logic key_hit(input logic [KEY_W-1:0] window, input int unsigned count);
		int unsigned n;
		n = key_span();
		if (count < n)
			return 1'b0;
		for (int unsigned j = 0; j < n; j++)
			if (key_reg[8*j +: 8] != window[8*(n-1-j) +: 8])
				return 1'b0;
		return 1'b1;
	endfunction

	// Advances the shadow parser by one character and queues the report at the line end.
	task automatic parse_char(input in_item_t it);
		logic [KEY_W-1:0] window;
		out_item_t res;
		if (kv_pos >= MAX_LINE) begin
			kv_overflow = 1'b1;
		end else begin
			window = {kv_recent, it.char_code};
			case (kv_phase)
				PH_KEY: begin
					if (key_hit(window, kv_pos + 1))
						kv_phase = PH_EQ;
				end
				PH_EQ: begin
					if (it.char_code == CHAR_EQUALS)
						kv_phase = PH_VALUE;
				end
				default: begin
					if (!is_blank(it.char_code)) begin
						if (!kv_seen_text) begin
							kv_start = kv_pos[7:0];
							kv_seen_text = 1'b1;
						end
						kv_last_text = kv_pos[7:0];
					end
				end
			endcase
			kv_recent = window[HIST_W-1:0];
			kv_pos = kv_pos + 1'b1;
		end
		if (it.last_char) begin
			res = '0;
			if (kv_overflow)
				res.status = ST_TOO_LONG;
			else if (kv_phase == PH_KEY)
				res.status = ST_NO_KEY;
			else if (kv_phase == PH_EQ)
				res.status = ST_NO_EQUALS;
			else if (!kv_seen_text)
				res.status = ST_EMPTY;
			else begin
				res.status = ST_OK;
				res.value_start = kv_start;
				res.value_length = {1'b0, kv_last_text} - {1'b0, kv_start} + 9'd1;
			end
			expected_fields.push_back(res);
			kv_recent = '0;
			kv_pos = '0;
			kv_phase = PH_KEY;
			kv_start = '0;
			kv_last_text = '0;
			kv_seen_text = 1'b0;
			kv_overflow = 1'b0;
		end
	endtask

	// Mostly no gap, sometimes a short one, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 30);
	endfunction

	// Sender: one transfer per accepted character, with random gaps between them while sender idling is on.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item <= '0;
			send_gap <= 0;
		end else begin
			if (in_valid && in_ready)
				parse_char(in_item);
			if (!in_valid || in_ready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (char_feed.size() != 0) begin
					in_item <= char_feed.pop_front();
					in_valid <= 1'b1;
					send_gap <= sender_idle_on ? pick_gap() : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each report transfer and stalls at random or on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_fields.size() == 0) begin
					$display("%0t: report with none expected: status %0d start %0d length %0d",
						$time, out_item.status, out_item.value_start, out_item.value_length);
					error_count++;
				end else begin
					want = expected_fields.pop_front();
					if (out_item.status !== want.status) begin
						$display("%0t: status expected %0d, got %0d",
							$time, want.status, out_item.status);
						error_count++;
					end
					if (out_item.value_start !== want.value_start) begin
						$display("%0t: value_start expected %0d, got %0d",
							$time, want.value_start, out_item.value_start);
						error_count++;
					end
					if (out_item.value_length !== want.value_length) begin
						$display("%0t: value_length expected %0d, got %0d",
							$time, want.value_length, out_item.value_length);
						error_count++;
					end
				end
			end
			if (hold_served != hold_requests) begin
				hold_served <= hold_served + 1;
				stall_left <= LONG_HOLD;
				out_ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (receiver_idle_on && $urandom_range(0, 3) == 0)
					stall_left <= pick_gap();
			end
		end
	end

	// Writes one key register while the block is idle and updates the shadow copy.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == REG_KEY_BYTES)
			key_reg = val;
		else
			key_len_reg = val[KLEN_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Waits for every owed report, then lets the pipeline drain.
	task automatic settle();
		do
			@(negedge clk);
		while (char_feed.size() != 0 || in_valid || expected_fields.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic queue_line(input logic [7:0] chars[$]);
		in_item_t it;
		for (int i = 0; i < chars.size(); i++) begin
			it.char_code = chars[i];
			it.last_char = (i == chars.size() - 1);
			char_feed.push_back(it);
		end
		chars_queued += chars.size();
	endtask

	task automatic queue_text(input string s);
		logic [7:0] chars[$];
		for (int i = 0; i < s.len(); i++)
			chars.push_back(s[i]);
		queue_line(chars);
	endtask

	function automatic logic [7:0] blank_char();
		int unsigned k;
		k = $urandom_range(0, 5);
		return (k == 5) ? CHAR_SPACE : 8'(9 + k);
	endfunction

	function automatic logic [7:0] text_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (is_blank(c));
		return c;
	endfunction

	// "id=" followed by a long value and one trailing blank, len characters in all.
	task automatic long_line(input int unsigned len);
		logic [7:0] chars[$];
		chars = {8'h69, 8'h64, CHAR_EQUALS};
		while (chars.size() < len - 1)
			chars.push_back(8'h76);
		chars.push_back(CHAR_SPACE);
		queue_line(chars);
	endtask

	// Mostly well-formed lines with random content; the rest lack the equals sign or the
	// value, carry a damaged key, or are plain noise.
	task automatic random_line(input int unsigned max_noise);
		logic [7:0] chars[$];
		int unsigned kind;
		int unsigned j;
		kind = $urandom_range(0, 99);
		if (kind < 85) begin
			repeat ($urandom_range(0, max_noise)) chars.push_back(8'($urandom_range(0, 255)));
			for (j = 0; j < key_span(); j++)
				chars.push_back(key_reg[8*j +: 8]);
			if (kind >= 75)
				chars[chars.size() - 1] = chars[chars.size() - 1] ^ 8'($urandom_range(1, 255));
			repeat ($urandom_range(0, 2)) chars.push_back(blank_char());
			if (kind < 65 || kind >= 75) begin
				chars.push_back(CHAR_EQUALS);
				repeat ($urandom_range(0, 3)) chars.push_back(blank_char());
				if (kind < 55 || kind >= 75) begin
					chars.push_back(text_char());
					repeat ($urandom_range(0, 7))
						chars.push_back(($urandom_range(0, 4) == 0) ? blank_char() : text_char());
					repeat ($urandom_range(0, 3)) chars.push_back(blank_char());
				end
			end else begin
				repeat ($urandom_range(0, 4)) chars.push_back(text_char());
			end
		end else begin
			repeat ($urandom_range(1, 12)) chars.push_back(8'($urandom_range(0, 255)));
		end
		queue_line(chars);
	endtask

	task automatic random_fill(input int unsigned count, input int unsigned max_noise);
		int unsigned mark;
		mark = chars_queued;
		while (chars_queued - mark < count)
			random_line(max_noise);
	endtask

	// Stimulus: a series of key settings, each followed by a full drain.
	initial begin
		logic [KEY_W-1:0] key_pick;
		int unsigned j;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset key: a single NUL character.
		random_fill(95, 4);
		settle();

		// Key "host": directed lines first.
		write_reg(REG_KEY_BYTES, 64'h74736F68);
		write_reg(REG_KEY_LENGTH, CFG_W'(4));
		@(negedge clk);
		queue_text("host =ab ");
		scratch = {8'hFF};
		queue_line(scratch);
		// The key split across two lines must not match.
		queue_text("ho");
		queue_text("st=");
		queue_text("host");
		queue_text("host= \t");
		random_fill(95, 4);
		settle();

		// Key "k=" with the equals sign inside it, and no idling on either side.
		sender_idle_on = 1'b0;
		receiver_idle_on = 1'b0;
		write_reg(REG_KEY_BYTES, 64'h3D6B);
		write_reg(REG_KEY_LENGTH, CFG_W'(2));
		@(negedge clk);
		queue_text("k==5");
		queue_text("k=");
		random_fill(95, 4);
		settle();

		// Longest key of all-ones characters.
		sender_idle_on = 1'b1;
		receiver_idle_on = 1'b1;
		write_reg(REG_KEY_BYTES, {KEY_W{1'b1}});
		write_reg(REG_KEY_LENGTH, CFG_W'(KEY_MAX));
		@(negedge clk);
		random_fill(95, 4);
		settle();

		// Key length above the maximum.
		write_reg(REG_KEY_BYTES, {$urandom, $urandom});
		write_reg(REG_KEY_LENGTH, CFG_W'(15));
		@(negedge clk);
		random_fill(95, 4);
		settle();

		// Key length zero; the receiver holds off while short lines keep coming.
		sender_idle_on = 1'b0;
		write_reg(REG_KEY_BYTES, {$urandom, $urandom});
		write_reg(REG_KEY_LENGTH, CFG_W'(0));
		@(negedge clk);
		random_fill(95, 0);
		hold_requests++;
		settle();

		// Key "id": a line of exactly the maximum length and one just over it.
		sender_idle_on = 1'b1;
		write_reg(REG_KEY_BYTES, 64'h6469);
		write_reg(REG_KEY_LENGTH, CFG_W'(2));
		@(negedge clk);
		long_line(MAX_LINE);
		long_line(MAX_LINE + 2);
		random_fill(95, 4);
		settle();

		// Printable key of random length.
		for (j = 0; j < KEY_MAX; j++)
			key_pick[8*j +: 8] = 8'($urandom_range(33, 126));
		write_reg(REG_KEY_BYTES, key_pick);
		write_reg(REG_KEY_LENGTH, CFG_W'($urandom_range(1, KEY_MAX)));
		@(negedge clk);
		random_fill(95, 4);
		settle();

		if (error_count == 0)
			$display("key_value_field_extractor verification clean");
		else
			$display("key_value_field_extractor verification failed");
		$finish;
	end

endmodule

@@ key_value_field_extractor.f @@
rtl/kvfe_pkg.sv
rtl/key_value_field_extractor.sv
sim/tb.sv
